### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### design/fpmm_pkg.sv
`default_nettype none

package fpmm_pkg;

  // word layout
  localparam int WORD_W    = 32;
  localparam int ITEM_COLS = 4;
  localparam int COL_W     = 2;
  localparam int ACT_W     = 2;
  localparam int TDATA_W   = 136;

  // input word kinds carried on tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_LEFT  = 2'd0,
    ACT_LOAD_RIGHT = 2'd1,
    ACT_MULTIPLY   = 2'd2
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPUTE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // control that travels with each product down the pipe
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [COL_W-1:0] col;
  } fpmm_tag_t;

  // one finished result element
  typedef struct packed {
    logic                     valid;
    logic [COL_W-1:0]         col;
    logic signed [WORD_W-1:0] value;
  } fpmm_elem_t;

endpackage

`default_nettype wire

### design/fixed_point_matrix_multiply_4x4.sv
`default_nettype none

// 4x4 fixed-point matrix multiply, signed s15.16 elements.
// input stream: tuser is the action. a load word writes one row of four elements
// into the left or right matrix; a multiply word starts result = left x right.
// tdata holds the row index and the four column elements.
// output stream: one word per result row with its row index and four saturated
// s15.16 elements; tlast marks the final row of a multiply.
// a single 32x32 multiplier feeds an exact accumulator, one product per cycle
// while computing, so each result row takes DIM*min(DIM,4) products, then drains
// through the store read, multiply, accumulate and result element registers
// into the row buffer that drives the output.
// the block takes no input word while a multiply runs or a row waits on the
// output. when the receiver stalls, the current row holds on the output and
// the computation of the next row does not start until it is taken.
// reset returns the sequencer to idle with no output pending; matrix contents
// are undefined until loaded.
module fixed_point_matrix_multiply_4x4 #(
  parameter int DIM = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row[1:0], col0, col1, col2, col3, zero pad
  input  logic [fpmm_pkg::TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [fpmm_pkg::ACT_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_row[1:0], out_col0, out_col1, out_col2, out_col3, zero pad
  output logic [fpmm_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import fpmm_pkg::*;

  localparam int NLIM = (DIM < ITEM_COLS) ? DIM : ITEM_COLS;
  localparam int RW   = $clog2(NLIM);
  localparam int KW   = $clog2(DIM);
  localparam int ROW_BITS = NLIM * WORD_W;

  state_t state;
  state_t state_next;

  logic [RW-1:0] i;
  logic [RW-1:0] j;
  logic [KW-1:0] k;
  logic          i_last;
  logic          j_last;
  logic          k_last;

  logic          accept_in;
  logic          accept_out;
  logic [COL_W-1:0]    in_row;
  logic                row_ok;
  logic [ROW_BITS-1:0] in_row_data;

  logic [ROW_BITS-1:0] lmem [NLIM];
  logic [ROW_BITS-1:0] rmem [NLIM];
  logic [ROW_BITS-1:0] lq;
  logic [ROW_BITS-1:0] rq;
  logic [KW-1:0]       k1;

  fpmm_tag_t                tag0;
  fpmm_tag_t                tag1;
  logic signed [WORD_W-1:0] op_a;
  logic signed [WORD_W-1:0] op_b;
  fpmm_elem_t               elem;
  logic                     row_done;

  logic signed [WORD_W-1:0] rowbuf [NLIM];

  assign accept_in   = s_axis_tvalid && s_axis_tready;
  assign accept_out  = m_axis_tvalid && m_axis_tready;
  assign in_row      = s_axis_tdata[COL_W-1:0];
  assign row_ok      = int'(in_row) < NLIM;
  assign in_row_data = s_axis_tdata[COL_W +: ROW_BITS];

  assign i_last = (i == RW'(NLIM - 1));
  assign j_last = (j == RW'(NLIM - 1));
  assign k_last = (k == KW'(DIM - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in && s_axis_tuser == ACT_MULTIPLY) begin
          state_next = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        if (j_last && k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (row_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (accept_out) begin
          state_next = i_last ? ST_IDLE : ST_COMPUTE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    tag0.valid    = 1'b0;
    case (state)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_COMPUTE: tag0.valid    = 1'b1;
      ST_DRAIN:   ;
      ST_EMIT:    m_axis_tvalid = 1'b1;
      default:    ;
    endcase
    tag0.first = (k == '0);
    tag0.last  = k_last;
    tag0.col   = COL_W'(j);
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept_in) begin
        i <= '0;
        j <= '0;
        k <= '0;
      end
      if (state == ST_COMPUTE) begin
        if (k_last) begin
          k <= '0;
          j <= j_last ? '0 : j + RW'(1);
        end else begin
          k <= k + KW'(1);
        end
      end
      if (state == ST_EMIT && accept_out) begin
        i <= i + RW'(1);
      end
    end
  end

  // row-wide matrix stores, written by load words
  always_ff @(posedge clk) begin
    if (accept_in && row_ok) begin
      if (s_axis_tuser == ACT_LOAD_LEFT) begin
        lmem[in_row[RW-1:0]] <= in_row_data;
      end
      if (s_axis_tuser == ACT_LOAD_RIGHT) begin
        rmem[in_row[RW-1:0]] <= in_row_data;
      end
    end
  end

  // registered store reads: left row i, right row k
  always_ff @(posedge clk) begin
    lq <= lmem[i];
    rq <= rmem[k[RW-1:0]];
    k1 <= k;
    if (rst) begin
      tag1.valid <= 1'b0;
    end else begin
      tag1.valid <= tag0.valid;
    end
    tag1.first <= tag0.first;
    tag1.last  <= tag0.last;
    tag1.col   <= tag0.col;
  end

  // operand select: left[i][k] and right[k][j]
  always_comb begin
    op_a = '0;
    if (int'(k1) < NLIM) begin
      op_a = lq[k1[RW-1:0] * WORD_W +: WORD_W];
    end
    op_b = rq[tag1.col[RW-1:0] * WORD_W +: WORD_W];
  end

  fpmm_mac #(
    .DIM (DIM)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag1),
    .a    (op_a),
    .b    (op_b),
    .elem (elem)
  );

  assign row_done = elem.valid && (elem.col == COL_W'(NLIM - 1));

  // result row buffer, also the output register
  always_ff @(posedge clk) begin
    if (elem.valid) begin
      rowbuf[elem.col[RW-1:0]] <= elem.value;
    end
  end

  // output word
  assign m_axis_tdata[COL_W-1:0] = COL_W'(i);
  assign m_axis_tlast            = i_last;
  assign m_axis_tdata[TDATA_W-1:COL_W + ITEM_COLS*WORD_W] = '0;

  for (genvar c = 0; c < ITEM_COLS; c++) begin : g_out_col
    if (c < NLIM) begin : g_used
      assign m_axis_tdata[COL_W + c*WORD_W +: WORD_W] = rowbuf[c];
    end else begin : g_zero
      assign m_axis_tdata[COL_W + c*WORD_W +: WORD_W] = '0;
    end
  end

endmodule

`default_nettype wire

### design/fpmm_mac.sv
`default_nettype none

module fpmm_mac #(
  parameter int DIM = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fpmm_pkg::fpmm_tag_t                tag,
  input  logic signed [fpmm_pkg::WORD_W-1:0] a,
  input  logic signed [fpmm_pkg::WORD_W-1:0] b,
  output fpmm_pkg::fpmm_elem_t               elem
);
  import fpmm_pkg::*;

  localparam int PROD_W = 2 * WORD_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int Q_W    = ACC_W - 16;
  localparam logic signed [Q_W-1:0] QMAX = Q_W'(signed'(32'h7FFF_FFFF));
  localparam logic signed [Q_W-1:0] QMIN = Q_W'(signed'(32'h8000_0000));

  logic signed [PROD_W-1:0] prod;
  fpmm_tag_t                tag2;
  logic signed [ACC_W-1:0]  acc;
  fpmm_tag_t                tag3;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [Q_W-1:0]    flo;
  logic signed [Q_W-1:0]    trunc_q;
  logic                     round_up;
  logic signed [WORD_W-1:0] sat_value;

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      tag2.valid <= 1'b0;
    end else begin
      tag2.valid <= tag.valid;
    end
    tag2.first <= tag.first;
    tag2.last  <= tag.last;
    tag2.col   <= tag.col;
  end

  // exact accumulate over the dot product
  assign prod_x = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc <= tag2.first ? prod_x : acc + prod_x;
    end
    if (rst) begin
      tag3.valid <= 1'b0;
    end else begin
      tag3.valid <= tag2.valid;
    end
    tag3.first <= tag2.first;
    tag3.last  <= tag2.last;
    tag3.col   <= tag2.col;
  end

  // shift by 16 toward zero, then saturate to 32 bits
  always_comb begin
    flo      = acc[ACC_W-1:16];
    round_up = acc[ACC_W-1] && (|acc[15:0]);
    trunc_q  = flo + Q_W'(round_up);
    if (trunc_q > QMAX) begin
      sat_value = QMAX[WORD_W-1:0];
    end else if (trunc_q < QMIN) begin
      sat_value = QMIN[WORD_W-1:0];
    end else begin
      sat_value = trunc_q[WORD_W-1:0];
    end
  end

  // result element register
  always_ff @(posedge clk) begin
    if (rst) begin
      elem.valid <= 1'b0;
    end else begin
      elem.valid <= tag3.valid && tag3.last;
    end
    elem.col   <= tag3.col;
    elem.value <= sat_value;
  end

endmodule

`default_nettype wire

### design/fpmm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fpmm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [fpmm_pkg::ACT_W-1:0]   s_axis_tuser,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [fpmm_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic                         m_axis_tlast
);
  import fpmm_pkg::*;

  logic mul_in;
  logic out_word;

  assign mul_in   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_MULTIPLY);
  assign out_word = m_axis_tvalid && m_axis_tready;

  // no new input word while a result row is offered
  `ASSERT_IMP(a_busy_while_out, m_axis_tvalid, !s_axis_tready)

  // a multiply keeps the block busy and cannot produce a row at once
  `ASSERT_NXT(a_mul_busy, mul_in, !s_axis_tready && !m_axis_tvalid)

  // each row needs fresh computation, so rows never come back to back
  `ASSERT_NXT(a_row_gap, out_word, !m_axis_tvalid)

  // a stalled row holds its word
  `ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind fixed_point_matrix_multiply_4x4 fpmm_checker u_fpmm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### test/fixed_point_matrix_multiply_4x4_test.sv
`default_nettype none

module fixed_point_matrix_multiply_4x4_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpmm_pkg::*;

  // action code the block must ignore
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [WORD_W-1:0] S_ONE = 32'sh00010000;
  localparam logic signed [WORD_W-1:0] S_NEG_ONE = 32'shffff0000;
  localparam logic signed [WORD_W-1:0] S_HALF = 32'sh00008000;

  // one input word plus a flag that holds it back until the output has drained
  typedef struct packed {
    logic                               sync_before;
    logic [ACT_W-1:0]                   action;
    logic [1:0]                         row;
    logic [ITEM_COLS-1:0][WORD_W-1:0]   cols;
  } matrix_word_t;

  typedef struct packed {
    logic [1:0]                         row;
    logic [ITEM_COLS-1:0][WORD_W-1:0]   cols;
    logic                               last;
  } result_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACT_W-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tlast;

  matrix_word_t pending_words[$];
  result_row_t  expected_rows[$];
  matrix_word_t cur_word;

  // predictor copy of both matrices
  logic signed [WORD_W-1:0] left_mat  [4][4];
  logic signed [WORD_W-1:0] right_mat [4][4];

  int mismatch_count = 0;
  int rows_checked = 0;
  int burst_left = 0;
  int gap_left = 0;
  int seg_left = 0;
  int ready_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  fixed_point_matrix_multiply_4x4 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exact dot product, truncated toward zero, saturated to 32 bits
  function automatic logic signed [WORD_W-1:0] dot_sat(int i, int j);
    logic signed [66:0] acc;
    logic signed [66:0] q;
    acc = '0;
    for (int k = 0; k < 4; k++)
      acc = acc + left_mat[i][k] * right_mat[k][j];
    q = acc / 67'sd65536;
    if (q > 67'sd2147483647)
      return S_MAX;
    if (q < -67'sd2147483648)
      return S_MIN;
    return q[WORD_W-1:0];
  endfunction

  // update the matrices and queue the rows a multiply gives
  function automatic void predict_word(matrix_word_t w);
    result_row_t r;
    case (w.action)
      ACT_LOAD_LEFT: begin
        for (int c = 0; c < 4; c++)
          left_mat[w.row][c] = w.cols[c];
      end
      ACT_LOAD_RIGHT: begin
        for (int c = 0; c < 4; c++)
          right_mat[w.row][c] = w.cols[c];
      end
      ACT_MULTIPLY: begin
        for (int i = 0; i < 4; i++) begin
          r.row = i[1:0];
          for (int j = 0; j < 4; j++)
            r.cols[j] = dot_sat(i, j);
          r.last = (i == 3);
          expected_rows.push_back(r);
        end
      end
      default: ; // unused action changes nothing
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h7ffff) - 32'h40000;
      2: begin
        case ($urandom_range(0, 5))
          0: return S_MAX;
          1: return S_MIN;
          2: return 32'h0;
          3: return 32'hffffffff;
          4: return S_ONE;
          default: return S_NEG_ONE;
        endcase
      end
      default: return $urandom_range(0, 32'h1ffffff) - 32'h1000000;
    endcase
  endfunction

  task automatic add_word(logic [ACT_W-1:0] act, logic [1:0] row,
                          logic [WORD_W-1:0] c0, logic [WORD_W-1:0] c1,
                          logic [WORD_W-1:0] c2, logic [WORD_W-1:0] c3,
                          logic sync = 1'b0);
    matrix_word_t w;
    w.sync_before = sync;
    w.action = act;
    w.row = row;
    w.cols = {c3, c2, c1, c0};
    pending_words.push_back(w);
  endtask

  task automatic note_mismatch(string what, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %0s: expected %h, got %h", what, want, got);
  endtask

  // input driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_word(cur_word);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() == 0 ||
                     (pending_words[0].sync_before && expected_rows.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          s_axis_tdata <= {6'b0, cur_word.cols, cur_word.row};
          s_axis_tuser <= cur_word.action;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // output ready: segments of steady, random and mostly stalled, plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && rows_checked >= 20) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(20, 80);
        ready_mode <= $urandom_range(0, 2);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // output monitor: compare each word against the oldest expected row
  always @(posedge clk) begin : monitor
    result_row_t                      want;
    logic [ITEM_COLS-1:0][WORD_W-1:0] got_cols;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_cols = m_axis_tdata[2 +: ITEM_COLS*WORD_W];
      if (expected_rows.size() == 0) begin
        note_mismatch("unexpected result word", '0, WORD_W'(m_axis_tdata[1:0]));
      end else begin
        want = expected_rows.pop_front();
        if (m_axis_tdata[1:0] !== want.row)
          note_mismatch("out_row", WORD_W'(want.row), WORD_W'(m_axis_tdata[1:0]));
        for (int c = 0; c < ITEM_COLS; c++)
          if (got_cols[c] !== want.cols[c])
            note_mismatch($sformatf("out_col%0d of row %0d", c, want.row),
                          want.cols[c], got_cols[c]);
        if (m_axis_tlast !== want.last)
          note_mismatch("last_row", WORD_W'(want.last), WORD_W'(m_axis_tlast));
      end
      rows_checked <= rows_checked + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int  random_items;
    int  kind;
    bit  first_sync;
    logic [ACT_W-1:0] side;

    // directed: extremes, saturation both ways, truncation of negative fractions
    add_word(ACT_LOAD_LEFT, 2'd0, S_MAX, S_MAX, S_MAX, S_MAX);
    add_word(ACT_LOAD_LEFT, 2'd1, S_MIN, S_MIN, S_MIN, S_MIN);
    add_word(ACT_LOAD_LEFT, 2'd2, S_ONE, S_NEG_ONE, 32'h1, 32'hffffffff);
    add_word(ACT_LOAD_LEFT, 2'd3, 32'h00018000, 32'h0, 32'h7fff0000, S_MIN);
    add_word(ACT_LOAD_RIGHT, 2'd0, S_MAX, S_MIN, S_ONE, 32'hffffffff);
    add_word(ACT_LOAD_RIGHT, 2'd1, S_MAX, S_MIN, S_ONE, 32'h1);
    add_word(ACT_LOAD_RIGHT, 2'd2, S_MIN, S_MAX, 32'h0, S_HALF);
    add_word(ACT_LOAD_RIGHT, 2'd3, S_MIN, S_MAX, 32'hffff8000, 32'h0);
    add_word(ACT_MULTIPLY, 2'd0, '0, '0, '0, '0);
    // ignored word with live data must leave the matrices untouched
    add_word(ACT_NONE, 2'd2, 32'hdeadbeef, 32'h12345678, 32'hffffffff, 32'h80000001);
    add_word(ACT_MULTIPLY, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    // identity-like right side, small left values
    add_word(ACT_LOAD_RIGHT, 2'd0, S_ONE, 32'h0, 32'h0, 32'h0);
    add_word(ACT_LOAD_RIGHT, 2'd1, 32'h0, S_ONE, 32'h0, 32'h0);
    add_word(ACT_LOAD_RIGHT, 2'd2, 32'h0, 32'h0, S_NEG_ONE, 32'h0);
    add_word(ACT_LOAD_RIGHT, 2'd3, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    add_word(ACT_LOAD_LEFT, 2'd1, 32'h1, 32'hffffffff, S_HALF, 32'h00030000);
    add_word(ACT_MULTIPLY, 2'd1, '0, '0, '0, '0, 1'b1);

    // random: mostly loads with random content and regular multiplies
    random_items = 0;
    first_sync = 1'b1;
    while (random_items < 200) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        add_word(ACT_NONE, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (kind <= 4) begin
        add_word(ACT_MULTIPLY, 2'($urandom()), $urandom(), $urandom(), $urandom(),
                 $urandom(), first_sync || ($urandom_range(0, 7) == 0));
        first_sync = 1'b0;
        random_items++;
      end else begin
        side = ($urandom_range(0, 1) == 0) ? ACT_LOAD_LEFT : ACT_LOAD_RIGHT;
        add_word(side, 2'($urandom()), rand_elem(), rand_elem(), rand_elem(), rand_elem());
        random_items++;
      end
    end
    add_word(ACT_MULTIPLY, 2'd0, '0, '0, '0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    while (expected_rows.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0 && expected_rows.size() == 0)
      $display("** fixed_point_matrix_multiply_4x4: PASSED **");
    else
      $display("** fixed_point_matrix_multiply_4x4: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("** fixed_point_matrix_multiply_4x4: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
